// File: hw/rtl/wjmc_pkg.sv
// Shared widths and constants for the windowed jump min-cost block.
package wjmc_pkg;

	localparam int HEIGHT_W = 16;
	localparam int COST_W = 32;
	localparam int JL_W = 5;
	localparam int MAX_JUMP_DEF = 16;
	localparam int JL_RESET = 1;
	localparam logic [COST_W-1:0] COST_MAX = '1;

endpackage

// File: hw/rtl/wjmc_if.sv
// Request and result channel interfaces for the windowed jump min-cost block.
interface wjmc_in_if;
	logic                           valid;
	logic                           ready;
	logic [wjmc_pkg::HEIGHT_W-1:0]  height;
	logic                           start_req;
	logic                           last_item;

	modport source(output valid, output height, output start_req, output last_item,
		input ready);
	modport sink(input valid, input height, input start_req, input last_item,
		output ready);
endinterface

interface wjmc_out_if;
	logic                         valid;
	logic                         ready;
	logic [wjmc_pkg::COST_W-1:0]  cost;
	logic                         is_final;

	modport source(output valid, output cost, output is_final, input ready);
	modport sink(input valid, input cost, input is_final, output ready);
endinterface

// File: hw/rtl/windowed_jump_min_cost.sv
// Top level: least-cost jump over a stream of heights, one shared compare unit.
// Usage:
//   items   : request channel (valid/ready) carrying height, start_req and
//             last_item. A request is taken at a clock edge with valid and ready high.
//   results : result channel (valid/ready) carrying cost and is_final; exactly
//             one result per request, in order.
//   jump_limit_we / jump_limit_wdata : write the jump limit (0 acts as 1, values
//             above MAX_JUMP act as MAX_JUMP). Write only while the block is idle.
// Flow: the first element of a sequence skips the scan and goes straight to
//   the write state. Any later element walks span = min(jump limit, elements
//   held) window entries through one shared abs-difference/add/compare unit,
//   one RAM read per cycle, through the RAM read and candidate registers, then
//   goes to the write state. The block takes the next request once the result has
//   moved into the output register.
// The window of heights and costs sits in one RAM of MAX_JUMP entries.
// Reset: jump limit 1, no sequence open, no result pending; RAM contents are
//   never read before written, so no clearing pass is needed.
// Stall: a result waits in the output register while the receiver holds ready
//   low; a following result waits in the sequencer until that register frees.
module windowed_jump_min_cost #(
	parameter int MAX_JUMP = wjmc_pkg::MAX_JUMP_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	wjmc_in_if.sink                     items,
	wjmc_out_if.source                  results,
	input  logic                        jump_limit_we,
	input  logic [wjmc_pkg::JL_W-1:0]   jump_limit_wdata
);

	localparam int CNT_W = $clog2(MAX_JUMP + 1);
	localparam int PTR_W = (MAX_JUMP > 1) ? $clog2(MAX_JUMP) : 1;
	localparam int HW = wjmc_pkg::HEIGHT_W;
	localparam int CW = wjmc_pkg::COST_W;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_WRITE = 3'b100
	} state_t;

	state_t                     state_q;
	logic [wjmc_pkg::JL_W-1:0]  jump_limit_q;
	logic [CNT_W-1:0]           filled_q;
	logic [CNT_W-1:0]           span_q;
	logic [CNT_W-1:0]           issue_cnt_q;
	logic [PTR_W-1:0]           wr_ptr_q;
	logic [PTR_W-1:0]           rd_ptr_q;
	logic [HW-1:0]              height_q;
	logic                       last_q;
	logic [CW-1:0]              best_q;
	logic                       vld_s1;
	logic                       vld_s2;
	logic [CW-1:0]              cand_s2;
	logic                       out_vld_q;
	logic [CW-1:0]              out_cost_q;
	logic                       out_final_q;

	logic                       accept;
	logic                       first_elem;
	logic [CNT_W-1:0]           lim_span;
	logic [CNT_W-1:0]           new_span;
	logic                       issue;
	logic                       scan_done;
	logic                       out_free;
	logic                       commit;
	logic [PTR_W-1:0]           wr_ptr_prev;
	logic [PTR_W-1:0]           rd_ptr_next;
	logic [PTR_W-1:0]           wr_ptr_next;
	logic [HW+CW-1:0]           ram_wdata;
	logic [HW+CW-1:0]           ram_rdata;
	logic [HW-1:0]              hist_height;
	logic [CW-1:0]              hist_cost;
	logic [HW-1:0]              diff;
	logic [CW:0]                sum;
	logic [CW-1:0]              cand;

	assign accept = items.valid && items.ready;
	assign items.ready = (state_q == ST_IDLE);
	assign first_elem = items.start_req || (filled_q == '0);

	// Clamp the jump limit to 1..MAX_JUMP, then to the elements held.
	always_comb begin
		if (jump_limit_q == '0) begin
			lim_span = CNT_W'(1);
		end else if (32'(jump_limit_q) > MAX_JUMP) begin
			lim_span = CNT_W'(MAX_JUMP);
		end else begin
			lim_span = CNT_W'(jump_limit_q);
		end
		new_span = (lim_span > filled_q) ? filled_q : lim_span;
	end

	assign wr_ptr_prev = (wr_ptr_q == '0) ? PTR_W'(MAX_JUMP - 1) : wr_ptr_q - 1'b1;
	assign rd_ptr_next = (rd_ptr_q == '0) ? PTR_W'(MAX_JUMP - 1) : rd_ptr_q - 1'b1;
	assign wr_ptr_next = (wr_ptr_q == PTR_W'(MAX_JUMP - 1)) ? '0 : wr_ptr_q + 1'b1;

	assign issue = (state_q == ST_SCAN) && (issue_cnt_q != span_q);
	assign scan_done = (issue_cnt_q == span_q) && !vld_s1 && !vld_s2;
	assign out_free = !out_vld_q || results.ready;
	assign commit = (state_q == ST_WRITE) && out_free;
	assign ram_wdata = {height_q, best_q};

	wjmc_ram #(
		.WIDTH(HW + CW),
		.DEPTH(MAX_JUMP)
	) u_window (
		.clk  (clk),
		.we   (commit),
		.waddr(wr_ptr_q),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	// Candidate: cost of the older element plus height difference, saturated.
	assign hist_height = ram_rdata[HW+CW-1:CW];
	assign hist_cost = ram_rdata[CW-1:0];
	assign diff = (height_q > hist_height) ? height_q - hist_height : hist_height - height_q;
	assign sum = {1'b0, hist_cost} + (CW + 1)'(diff);
	assign cand = sum[CW] ? wjmc_pkg::COST_MAX : sum[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_limit_q <= wjmc_pkg::JL_W'(wjmc_pkg::JL_RESET);
		end else if (jump_limit_we) begin
			jump_limit_q <= jump_limit_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			filled_q    <= '0;
			wr_ptr_q    <= '0;
			issue_cnt_q <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			// load a new result, or drop the one taken by the receiver
			if (commit) begin
				out_vld_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						issue_cnt_q <= '0;
						if (items.start_req) begin
							filled_q <= '0;
						end
						state_q <= first_elem ? ST_WRITE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						issue_cnt_q <= issue_cnt_q + 1'b1;
					end
					if (scan_done) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (out_free) begin
						wr_ptr_q  <= wr_ptr_next;
						if (last_q) begin
							filled_q <= '0;
						end else if (filled_q < CNT_W'(MAX_JUMP)) begin
							filled_q <= filled_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			height_q <= items.height;
			last_q   <= items.last_item;
			span_q   <= new_span;
			rd_ptr_q <= wr_ptr_prev;
			best_q   <= first_elem ? '0 : wjmc_pkg::COST_MAX;
		end else begin
			if (issue) begin
				rd_ptr_q <= rd_ptr_next;
			end
			if (vld_s2 && (cand_s2 < best_q)) begin
				best_q <= cand_s2;
			end
		end
		cand_s2 <= cand;
		if (commit) begin
			out_cost_q  <= best_q;
			out_final_q <= last_q;
		end
	end

	assign results.valid = out_vld_q;
	assign results.cost = out_cost_q;
	assign results.is_final = out_final_q;

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(filled_q) <= MAX_JUMP)
		else $error("window fill count beyond depth");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (issue_cnt_q <= span_q))
		else $error("more window reads than span");

	a_start_skips_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && items.start_req) |=> (state_q == ST_WRITE))
		else $error("start element did not skip the scan");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && last_q) |=> (filled_q == '0))
		else $error("final element left window filled");

	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (out_vld_q && (out_cost_q == $past(best_q))))
		else $error("result register not loaded with best cost");
`endif

endmodule

// File: hw/rtl/wjmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wjmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
